// ----- src/hta_pkg.sv -----
// Shared types and constants of the handle table allocator.
package hta_pkg;

  localparam int ACTION_W  = 3;
  localparam int OWNER_W   = 8;
  localparam int TYPE_W    = 2;
  localparam int PAYLOAD_W = 32;
  localparam int GEN_W     = 16;
  localparam int INDEX_W   = 16;
  localparam int HANDLE_W  = GEN_W + INDEX_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  localparam logic [OWNER_W-1:0] FREE_OWNER = 8'hFF;
  localparam logic [OWNER_W-1:0] ANY_OWNER  = 8'h00;
  localparam logic [TYPE_W-1:0]  ANY_TYPE   = 2'd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE        = 3'd0,
    ACT_DESTROY       = 3'd1,
    ACT_DESTROY_OWNER = 3'd2,
    ACT_GET_DATA      = 3'd3,
    ACT_SET_DATA      = 3'd4
  } action_t;

  typedef struct packed {
    logic [GEN_W-1:0]     gen;
    logic [OWNER_W-1:0]   owner;
    logic [TYPE_W-1:0]    typ;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{gen: '0, owner: FREE_OWNER, typ: '0, payload: '0};

endpackage

// ----- src/hta_store.sv -----
// Slot memory with one write and one registered read port, plus per-slot written bits.
module hta_store
  import hta_pkg::*;
#(
  parameter int NUM_SLOTS = 32,
  parameter int AW = $clog2(NUM_SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry
);

  entry_t               mem [NUM_SLOTS];
  entry_t               rd_raw;
  logic                 rd_vld;
  logic [NUM_SLOTS-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // A slot never written reads as free with generation zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld ? rd_raw : ENTRY_RESET;

endmodule

// ----- src/hta_ctrl.sv -----
// Sequencer that reads, checks and writes back slots and drives the result register.
module hta_ctrl
  import hta_pkg::*;
#(
  parameter int NUM_SLOTS = 32,
  parameter int AW = $clog2(NUM_SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  entry_t                rd_entry,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output entry_t                wr_entry
);

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_SCAN, ST_DONE} state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic                 ok;
    logic [PAYLOAD_W-1:0] data;
    logic [TYPE_W-1:0]    typ;
    logic                 freed;
    logic                 last;
  } result_t;

  state_t               state, state_next;
  action_t              act;
  logic [OWNER_W-1:0]   owner_r;
  logic [TYPE_W-1:0]    type_r;
  logic [PAYLOAD_W-1:0] data_r;
  logic [AW-1:0]        idx, idx_next;
  logic                 out_valid;
  result_t              out_r, res;
  logic                 load;

  logic                 accept;
  action_t              in_act;
  logic [INDEX_W-1:0]   in_idx;
  logic                 in_bad;
  logic                 slot_free;
  logic                 owner_ok;
  logic                 type_ok;
  logic                 out_free;
  logic                 last_idx;
  logic [GEN_W-1:0]     gen_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_act        = action_t'(s_axis_tuser);
  assign in_idx        = s_axis_tdata[INDEX_W-1:0];
  assign in_bad        = (in_idx == '0) || (in_idx >= INDEX_W'(NUM_SLOTS));

  assign slot_free = (rd_entry.owner == FREE_OWNER);
  assign owner_ok  = (owner_r == ANY_OWNER) || (rd_entry.owner == owner_r);
  assign type_ok   = (type_r == ANY_TYPE) || (rd_entry.typ == type_r);
  assign out_free  = !out_valid || m_axis_tready;
  assign last_idx  = (idx == AW'(NUM_SLOTS - 1));
  assign gen_next  = rd_entry.gen + 16'd1;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    res        = '0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_entry   = rd_entry;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_CREATE: begin
              rd_en      = 1'b1;
              rd_addr    = AW'(1);
              idx_next   = AW'(1);
              state_next = ST_SCAN;
            end
            ACT_DESTROY_OWNER: begin
              // Owner 255 is the free mark and never owns a slot.
              if (s_axis_tdata[HANDLE_W +: OWNER_W] == FREE_OWNER) begin
                state_next = ST_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = AW'(1);
                idx_next   = AW'(1);
                state_next = ST_SCAN;
              end
            end
            ACT_DESTROY, ACT_GET_DATA, ACT_SET_DATA: begin
              if (in_bad) begin
                state_next = ST_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = in_idx[AW-1:0];
                idx_next   = in_idx[AW-1:0];
                state_next = ST_LOOK;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          load       = 1'b1;
          res.last   = 1'b1;
          state_next = ST_IDLE;
          case (act)
            ACT_DESTROY: begin
              if (!slot_free && owner_ok) begin
                res.ok   = 1'b1;
                res.data = rd_entry.payload;
                res.typ  = rd_entry.typ;
                res.freed = 1'b1;
                wr_en            = 1'b1;
                wr_entry.owner   = FREE_OWNER;
                wr_entry.payload = '0;
              end
            end
            ACT_GET_DATA: begin
              if (!slot_free && owner_ok && type_ok) begin
                res.ok   = 1'b1;
                res.data = rd_entry.payload;
              end
            end
            ACT_SET_DATA: begin
              if (!slot_free) begin
                res.ok           = 1'b1;
                wr_en            = 1'b1;
                wr_entry.payload = data_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (act == ACT_CREATE) begin
          if (slot_free) begin
            if (out_free) begin
              wr_en      = 1'b1;
              wr_entry   = '{gen: gen_next, owner: owner_r, typ: type_r, payload: data_r};
              load       = 1'b1;
              res.handle = {gen_next, INDEX_W'(idx)};
              res.ok     = 1'b1;
              res.last   = 1'b1;
              state_next = ST_IDLE;
            end
          end else if (last_idx) begin
            state_next = ST_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = idx + 1'b1;
            idx_next   = idx + 1'b1;
          end
        end else begin
          // The next slot is read while the current one is written back.
          if ((rd_entry.owner != owner_r) || out_free) begin
            if (rd_entry.owner == owner_r) begin
              wr_en            = 1'b1;
              wr_entry.owner   = FREE_OWNER;
              wr_entry.payload = '0;
              load             = 1'b1;
              res.ok           = 1'b1;
              res.data         = rd_entry.payload;
              res.typ          = rd_entry.typ;
              res.freed        = 1'b1;
            end
            if (last_idx) begin
              state_next = ST_DONE;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = idx + 1'b1;
              idx_next = idx + 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          res.ok     = (act == ACT_DESTROY_OWNER);
          res.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_r <= res;
    end
    if (accept) begin
      act     <= in_act;
      owner_r <= s_axis_tdata[HANDLE_W +: OWNER_W];
      type_r  <= s_axis_tdata[HANDLE_W+OWNER_W +: TYPE_W];
      data_r  <= s_axis_tdata[HANDLE_W+OWNER_W+TYPE_W +: PAYLOAD_W];
    end
    idx <= idx_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_r.typ, out_r.data, out_r.ok, out_r.handle};
  assign m_axis_tuser  = out_r.freed;
  assign m_axis_tlast  = out_r.last;

endmodule

// ----- src/handle_table_allocator.sv -----
// Handle table allocator: generational slot table over one slot memory.
// Destroy, get data and set data: the indexed slot is read and checked in ST_LOOK, then the result is registered.
// Create scans slots from index 1, one per cycle, until it finds a free slot or passes the last one (full table).
// Destroy-owner scans every slot from index 1, one per cycle plus output stalls, then the final result.
// One transaction in flight at a time, so a new one is taken only once the last result is registered.
// Reset clears the per-slot written bits; all slots read as free.
module handle_table_allocator
  import hta_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] handle_in, [39:32] owner_id, [41:40] type_code, [73:42] data_in, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] action
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] handle_out, [32] ok, [64:33] data_out, [66:65] type_out, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] freed
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int AW = $clog2(NUM_SLOTS);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;

  hta_store #(
    .NUM_SLOTS(NUM_SLOTS),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_entry(rd_entry),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_entry(wr_entry)
  );

  hta_ctrl #(
    .NUM_SLOTS(NUM_SLOTS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_entry(rd_entry),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_entry(wr_entry)
  );

  // A write never lands on the slot being read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("slot read and write collide");

  // Only one transaction is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A freed entry is always reported as a success.
  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[32])
    else $error("freed result without ok");

  // A nonzero handle index only comes from a successful create.
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[15:0] != 16'd0) |-> m_axis_tdata[32] && m_axis_tlast)
    else $error("handle returned without success");

endmodule
